// ----- hw/rtl/ams_pkg.sv -----
package ams_pkg;

    localparam int unsigned NOW_W      = 32;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam int unsigned RAPID_WINDOW    = 600;
    localparam int unsigned HOUR_SECONDS    = 3600;
    localparam int unsigned STEP_SMALL      = 15;
    localparam int unsigned STEP_LARGE      = 30;
    localparam int unsigned RAPID_MIN_COUNT = 2;

    localparam logic [LEVEL_W-1:0]    MAX_LEVEL_RST  = 8'd255;
    localparam logic [LEVEL_W-1:0]    THRESHOLD_RST  = 8'd5;
    localparam logic [CFG_IDX_W-1:0]  CFG_MAX_LEVEL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_ACT_THRESH = 1'd1;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_RAPID  = 2'd1,
        CAUSE_HOURLY = 2'd2,
        CAUSE_RAISE  = 2'd3
    } cause_t;

    typedef struct packed {
        logic [0:0]       cmd;
        logic [NOW_W-1:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [0:0]         write_pot;
        cause_t             cause;
    } out_item_t;

    // nearest multiple of 15; (x * 137) >> 11 equals x / 15 for x up to 262
    function automatic logic [LEVEL_W-1:0] round_to_step(input logic [LEVEL_W-1:0] v);
        logic [8:0]  x;
        logic [17:0] prod;
        logic [4:0]  q;
        logic [9:0]  r;
        x    = {1'b0, v} + 9'd7;
        prod = 18'(x) * 18'd137;
        q    = prod[15:11];
        r    = 10'(q) * 10'(STEP_SMALL);
        return r[LEVEL_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/adaptive_motion_sensitivity_unit.sv -----
// Path: an accepted item is held in the input register until the result register is free.
// Throughput: one item per cycle unless the output stalls; the whole update is one combinational pass
// between the input register and the result register; the state registers load together with it.
// Reset (rst_n, async, active low): level 255, max 255, threshold 5,
// event times and counters 0, both pipeline registers empty.
module adaptive_motion_sensitivity_unit #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ams_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ams_pkg::out_item_t                  out_data,
    input  logic                                cfg_wr_en,
    input  logic [ams_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [ams_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import ams_pkg::*;

    localparam int unsigned NOW_EXT_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

    logic                  in_vld_reg;
    in_item_t              in_item_reg;
    logic                  out_vld_reg;
    out_item_t             out_item_reg;

    logic [LEVEL_W-1:0]    max_level_reg,   max_level_next;
    logic [LEVEL_W-1:0]    threshold_reg,   threshold_next;
    logic [LEVEL_W-1:0]    sens_level_reg,  sens_level_next;
    logic [TIME_BITS-1:0]  last_adj_reg,    last_adj_next;
    logic [TIME_BITS-1:0]  last_raise_reg,  last_raise_next;
    logic [CNT_W-1:0]      hour_cnt_reg,    hour_cnt_next;
    logic [CNT_W-1:0]      raise_cnt_reg,   raise_cnt_next;
    out_item_t             result_next;

    logic                  proc;
    logic                  act;
    logic [NOW_EXT_W-1:0]  now_ext;
    logic [TIME_BITS-1:0]  now_val;
    logic [TIME_BITS-1:0]  since_adj;
    logic [TIME_BITS-1:0]  since_raise;
    logic                  rapid;
    logic                  hourly;
    logic                  counted;
    logic                  raise;
    logic [CNT_W-1:0]      hour_cnt_inc;
    logic [CNT_W-1:0]      raise_cnt_inc;
    logic [CNT_W-1:0]      hour_cnt_act;
    logic [LEVEL_W-1:0]    level_lowered;
    logic [LEVEL_W:0]      level_raised;
    logic [LEVEL_W-1:0]    cfg_rounded;

    assign proc      = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || proc;
    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

    assign act         = in_item_reg.cmd[0];
    assign now_ext     = NOW_EXT_W'(in_item_reg.now_seconds);
    assign now_val     = now_ext[TIME_BITS-1:0];
    assign since_adj   = now_val - last_adj_reg;
    assign since_raise = now_val - last_raise_reg;

    assign hour_cnt_inc  = (&hour_cnt_reg)  ? hour_cnt_reg  : hour_cnt_reg  + 1'b1;
    assign raise_cnt_inc = (&raise_cnt_reg) ? raise_cnt_reg : raise_cnt_reg + 1'b1;

    assign rapid   = act && (since_raise <= TIME_BITS'(RAPID_WINDOW))
                     && (raise_cnt_reg >= CNT_W'(RAPID_MIN_COUNT));
    assign hourly  = act && !rapid && (hour_cnt_reg >= CNT_W'(threshold_reg))
                     && (since_adj < TIME_BITS'(HOUR_SECONDS));
    assign counted = act && !rapid && !hourly;
    assign raise   = !rapid && !hourly && (since_adj >= TIME_BITS'(HOUR_SECONDS));

    assign hour_cnt_act  = counted ? hour_cnt_inc : hour_cnt_reg;
    assign level_lowered = (sens_level_reg >= LEVEL_W'(STEP_SMALL))
                           ? sens_level_reg - LEVEL_W'(STEP_SMALL) : '0;
    assign level_raised  = {1'b0, sens_level_reg}
                           + (((hour_cnt_act <= CNT_W'(1)) && (sens_level_reg < max_level_reg))
                              ? (LEVEL_W+1)'(STEP_LARGE) : (LEVEL_W+1)'(STEP_SMALL));
    assign cfg_rounded   = round_to_step(cfg_wdata);

    always_comb
    begin
        max_level_next  = max_level_reg;
        threshold_next  = threshold_reg;
        sens_level_next = sens_level_reg;
        last_adj_next   = last_adj_reg;
        last_raise_next = last_raise_reg;
        hour_cnt_next   = hour_cnt_reg;
        raise_cnt_next  = raise_cnt_reg;
        result_next.write_pot = 1'b0;
        result_next.cause     = CAUSE_NONE;

        if (proc)
        begin
            if (rapid)
            begin
                sens_level_next       = level_lowered;
                raise_cnt_next        = '0;
                last_raise_next       = '0;
                result_next.write_pot = 1'b1;
                result_next.cause     = CAUSE_RAPID;
            end
            else if (hourly)
            begin
                sens_level_next       = level_lowered;
                hour_cnt_next         = '0;
                last_adj_next         = now_val;
                raise_cnt_next        = '0;
                result_next.write_pot = 1'b1;
                result_next.cause     = CAUSE_HOURLY;
            end
            else if (raise)
            begin
                sens_level_next       = (level_raised > {1'b0, max_level_reg})
                                        ? max_level_reg : level_raised[LEVEL_W-1:0];
                last_raise_next       = now_val;
                raise_cnt_next        = '0;
                hour_cnt_next         = '0;
                last_adj_next         = now_val;
                result_next.write_pot = 1'b1;
                result_next.cause     = CAUSE_RAISE;
            end
            else if (counted)
            begin
                hour_cnt_next  = hour_cnt_inc;
                raise_cnt_next = raise_cnt_inc;
            end
        end

        result_next.level = sens_level_next;

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_MAX_LEVEL:
                begin
                    max_level_next  = cfg_rounded;
                    sens_level_next = cfg_rounded;
                end
                CFG_ACT_THRESH: threshold_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            max_level_reg  <= MAX_LEVEL_RST;
            threshold_reg  <= THRESHOLD_RST;
            sens_level_reg <= MAX_LEVEL_RST;
            last_adj_reg   <= '0;
            last_raise_reg <= '0;
            hour_cnt_reg   <= '0;
            raise_cnt_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (proc)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            max_level_reg  <= max_level_next;
            threshold_reg  <= threshold_next;
            sens_level_reg <= sens_level_next;
            last_adj_reg   <= last_adj_next;
            last_raise_reg <= last_raise_next;
            hour_cnt_reg   <= hour_cnt_next;
            raise_cnt_reg  <= raise_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (proc)
        begin
            out_item_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_level_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        sens_level_reg <= max_level_reg)
        else $error("level above ceiling");

    a_pot_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_item_reg.write_pot[0] == (out_item_reg.cause != CAUSE_NONE)))
        else $error("write_pot disagrees with cause");

    a_rapid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && rapid && !cfg_wr_en) |=> (raise_cnt_reg == '0 && last_raise_reg == '0))
        else $error("rapid decrease did not clear raise tracking");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_vld_reg)
        else $error("processed item left no result");
`endif

endmodule
